### rtl/bw_pkg.sv
package bw_pkg;

    // Field and datapath widths.
    localparam int CoordW   = 16;
    localparam int EdgeW    = CoordW + 1;
    localparam int ProdW    = 2 * EdgeW;
    localparam int CrossW   = ProdW + 1;
    localparam int MagW     = CrossW - 1;
    localparam int FracW    = 16;
    localparam int QuotW    = MagW + FracW;
    localparam int RemW     = MagW + 1;
    localparam int SqW      = QuotW + 1;
    localparam int SumW     = QuotW + 3;
    localparam int WeightW  = 25;
    localparam int InDataW  = 8 * CoordW;
    localparam int OutDataW = ((3 * WeightW + 7) / 8) * 8;
    localparam int OutUserW = 2;
    localparam int PadW     = OutDataW - 3 * WeightW;

    // Fixed point one and the weight range, at the width of the weight sum.
    localparam logic signed [SumW-1:0] OneQ16 = SumW'(longint'(1) <<< FracW);
    localparam logic signed [SumW-1:0] WMaxS  = SumW'((longint'(1) <<< (WeightW - 1)) - 1);
    localparam logic signed [SumW-1:0] WMinS  = SumW'(-(longint'(1) <<< (WeightW - 1)));

    // Sign and degenerate flags that travel alongside the divider lanes.
    typedef struct packed {
        logic q1_neg;
        logic q2_neg;
        logic degen;
    } t_div_ctl;

    // One step of restoring division.
    typedef struct packed {
        logic [MagW-1:0]  rem;
        logic [QuotW-1:0] x;
    } t_div_st;

    typedef struct packed {
        logic [WeightW-1:0] w;
        logic               sat;
    } t_sat_w;

    function automatic logic signed [EdgeW-1:0] ext_coord(input logic [CoordW-1:0] v);
        return $signed({v[CoordW-1], v});
    endfunction

    // Shift in the next dividend bit, subtract the divisor when it fits.
    function automatic t_div_st div_step(input t_div_st s, input logic [MagW-1:0] d);
        logic [RemW-1:0] t;
        logic            q;
        t_div_st         r;
        t = {s.rem, s.x[QuotW-1]};
        q = (t >= {1'b0, d});
        if (q) begin
            t = t - {1'b0, d};
        end
        r.rem = t[MagW-1:0];
        r.x   = {s.x[QuotW-2:0], q};
        return r;
    endfunction

    // Clamp a wide signed weight into the Q8.16 range.
    function automatic t_sat_w clamp_w(input logic signed [SumW-1:0] v);
        t_sat_w r;
        r.sat = 1'b1;
        if (v > WMaxS) begin
            r.w = WMaxS[WeightW-1:0];
        end else if (v < WMinS) begin
            r.w = WMinS[WeightW-1:0];
        end else begin
            r.w   = v[WeightW-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

### rtl/triangle_barycentric_weights.sv
// Barycentric weights of a query point against a screen-space triangle. Each input word carries
// the three vertices and the point in signed Q12.4; each output word carries the weights of A, B
// and C in signed Q8.16, with weight A formed as one minus the other two before clipping. A zero
// area gives zero weights and sets the degenerate flag; any weight clipped to the Q8.16 range sets
// the saturated flag. The block takes one word per clock unless it is full and stalled, and holds
// no state between words. The pipeline has stages for edge vectors and cross products, the two
// restoring dividers that produce one quotient bit per stage, and signs, clipping and the output
// register. Stalls propagate stage by stage, so empty stages keep filling while the output waits.
module triangle_barycentric_weights (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // ax, ay, bx, by_coord, cx, cy, px, py (16 bits each)
    input  logic [bw_pkg::InDataW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // weight_a, weight_b, weight_c (25 bits each), zero fill
    output logic [bw_pkg::OutDataW-1:0]   m_axis_tdata,
    // degenerate, saturated
    output logic [bw_pkg::OutUserW-1:0]   m_axis_tuser
);
    import bw_pkg::*;

    logic               w_x_valid, w_x_ready;
    logic [MagW-1:0]    w_n1_mag, w_n2_mag, w_area_mag;
    t_div_ctl           w_x_ctl;
    logic               w_d_valid, w_d_ready;
    logic [QuotW-1:0]   w_q1_mag, w_q2_mag;
    t_div_ctl           w_d_ctl;
    logic [WeightW-1:0] w_wa, w_wb, w_wc;
    logic               w_degen, w_sat;

    bw_cross u_cross (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .o_valid    (w_x_valid),
        .i_ready    (w_x_ready),
        .o_n1_mag   (w_n1_mag),
        .o_n2_mag   (w_n2_mag),
        .o_area_mag (w_area_mag),
        .o_ctl      (w_x_ctl)
    );

    bw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_x_valid),
        .o_ready    (w_x_ready),
        .i_n1_mag   (w_n1_mag),
        .i_n2_mag   (w_n2_mag),
        .i_area_mag (w_area_mag),
        .i_ctl      (w_x_ctl),
        .o_valid    (w_d_valid),
        .i_ready    (w_d_ready),
        .o_q1_mag   (w_q1_mag),
        .o_q2_mag   (w_q2_mag),
        .o_ctl      (w_d_ctl)
    );

    bw_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_d_valid),
        .o_ready    (w_d_ready),
        .i_q1_mag   (w_q1_mag),
        .i_q2_mag   (w_q2_mag),
        .i_ctl      (w_d_ctl),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_weight_a (w_wa),
        .o_weight_b (w_wb),
        .o_weight_c (w_wc),
        .o_degen    (w_degen),
        .o_sat      (w_sat)
    );

    assign m_axis_tdata = {{PadW{1'b0}}, w_wc, w_wb, w_wa};
    assign m_axis_tuser = {w_sat, w_degen};

    // A degenerate word carries zero weights and never reports saturation.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_degen) |-> (w_wa == '0 && w_wb == '0 && w_wc == '0 && !w_sat))
        else $error("degenerate word with nonzero weights or saturation");

    // Unclipped weights always sum to exactly one.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_degen && !w_sat) |->
        (($signed({{2{w_wa[WeightW-1]}}, w_wa}) + $signed({{2{w_wb[WeightW-1]}}, w_wb})
          + $signed({{2{w_wc[WeightW-1]}}, w_wc})) == (WeightW+2)'(OneQ16)))
        else $error("weights do not sum to one");

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !w_d_valid && !w_x_valid))
        else $error("pipeline not empty after reset");

endmodule

### rtl/bw_cross.sv
module bw_cross (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bw_pkg::InDataW-1:0]   i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bw_pkg::MagW-1:0]      o_n1_mag,
    output logic [bw_pkg::MagW-1:0]      o_n2_mag,
    output logic [bw_pkg::MagW-1:0]      o_area_mag,
    output bw_pkg::t_div_ctl             o_ctl
);
    import bw_pkg::*;

    logic [3:0] r_v;
    logic [3:0] w_rdy;

    logic signed [EdgeW-1:0]  r_abx, r_aby, r_acx, r_acy, r_apx, r_apy;
    logic signed [ProdW-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [CrossW-1:0] r_area, r_n1, r_n2;
    logic [MagW-1:0]          r_n1_mag, r_n2_mag, r_area_mag;
    t_div_ctl                 r_ctl;
    logic signed [EdgeW-1:0]  w_ax, w_ay;

    // A stage takes a new word when it is empty or its successor moves.
    assign w_rdy[3] = !r_v[3] || i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    assign w_ax = ext_coord(i_data[0*CoordW +: CoordW]);
    assign w_ay = ext_coord(i_data[1*CoordW +: CoordW]);

    // Edge vectors relative to vertex A.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_abx <= ext_coord(i_data[2*CoordW +: CoordW]) - w_ax;
            r_aby <= ext_coord(i_data[3*CoordW +: CoordW]) - w_ay;
            r_acx <= ext_coord(i_data[4*CoordW +: CoordW]) - w_ax;
            r_acy <= ext_coord(i_data[5*CoordW +: CoordW]) - w_ay;
            r_apx <= ext_coord(i_data[6*CoordW +: CoordW]) - w_ax;
            r_apy <= ext_coord(i_data[7*CoordW +: CoordW]) - w_ay;
        end
    end

    // Six partial products of the three cross products.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_p0 <= r_abx * r_acy;
            r_p1 <= r_aby * r_acx;
            r_p2 <= r_apx * r_acy;
            r_p3 <= r_apy * r_acx;
            r_p4 <= r_abx * r_apy;
            r_p5 <= r_aby * r_apx;
        end
    end

    // Doubled area and the two sub-areas.
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_area <= {r_p0[ProdW-1], r_p0} - {r_p1[ProdW-1], r_p1};
            r_n1   <= {r_p2[ProdW-1], r_p2} - {r_p3[ProdW-1], r_p3};
            r_n2   <= {r_p4[ProdW-1], r_p4} - {r_p5[ProdW-1], r_p5};
        end
    end

    // Magnitudes and quotient signs for the dividers.
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_area_mag   <= r_area[CrossW-1] ? MagW'(-r_area) : r_area[MagW-1:0];
            r_n1_mag     <= r_n1[CrossW-1] ? MagW'(-r_n1) : r_n1[MagW-1:0];
            r_n2_mag     <= r_n2[CrossW-1] ? MagW'(-r_n2) : r_n2[MagW-1:0];
            r_ctl.q1_neg <= r_n1[CrossW-1] ^ r_area[CrossW-1];
            r_ctl.q2_neg <= r_n2[CrossW-1] ^ r_area[CrossW-1];
            r_ctl.degen  <= (r_area == '0);
        end
    end

    assign o_valid    = r_v[3];
    assign o_n1_mag   = r_n1_mag;
    assign o_n2_mag   = r_n2_mag;
    assign o_area_mag = r_area_mag;
    assign o_ctl      = r_ctl;

endmodule

### rtl/bw_div.sv
module bw_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bw_pkg::MagW-1:0]      i_n1_mag,
    input  logic [bw_pkg::MagW-1:0]      i_n2_mag,
    input  logic [bw_pkg::MagW-1:0]      i_area_mag,
    input  bw_pkg::t_div_ctl             i_ctl,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bw_pkg::QuotW-1:0]     o_q1_mag,
    output logic [bw_pkg::QuotW-1:0]     o_q2_mag,
    output bw_pkg::t_div_ctl             o_ctl
);
    import bw_pkg::*;

    // One quotient bit per stage, two lanes sharing divisor and control.
    logic [QuotW-1:0] r_v;
    logic [QuotW:0]   w_rdy;
    t_div_st          r_s1 [QuotW];
    t_div_st          r_s2 [QuotW];
    logic [MagW-1:0]  r_d  [QuotW];
    t_div_ctl         r_ctl[QuotW];

    logic             w_v  [QuotW+1];
    t_div_st          w_s1 [QuotW+1];
    t_div_st          w_s2 [QuotW+1];
    logic [MagW-1:0]  w_d  [QuotW+1];
    t_div_ctl         w_ctl[QuotW+1];

    // The first stage sees the scaled dividends with a cleared remainder.
    assign w_v[0]       = i_valid;
    assign w_s1[0].rem  = '0;
    assign w_s1[0].x    = {i_n1_mag, {FracW{1'b0}}};
    assign w_s2[0].rem  = '0;
    assign w_s2[0].x    = {i_n2_mag, {FracW{1'b0}}};
    assign w_d[0]       = i_area_mag;
    assign w_ctl[0]     = i_ctl;
    assign w_rdy[QuotW] = i_ready;

    for (genvar k = 0; k < QuotW; k++) begin : g_stage
        assign w_rdy[k]   = !r_v[k] || w_rdy[k+1];
        assign w_v[k+1]   = r_v[k];
        assign w_s1[k+1]  = r_s1[k];
        assign w_s2[k+1]  = r_s2[k];
        assign w_d[k+1]   = r_d[k];
        assign w_ctl[k+1] = r_ctl[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_s1[k]  <= div_step(w_s1[k], w_d[k]);
                r_s2[k]  <= div_step(w_s2[k], w_d[k]);
                r_d[k]   <= w_d[k];
                r_ctl[k] <= w_ctl[k];
            end
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = w_v[QuotW];
    assign o_q1_mag = w_s1[QuotW].x;
    assign o_q2_mag = w_s2[QuotW].x;
    assign o_ctl    = w_ctl[QuotW];

endmodule

### rtl/bw_out.sv
module bw_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bw_pkg::QuotW-1:0]      i_q1_mag,
    input  logic [bw_pkg::QuotW-1:0]      i_q2_mag,
    input  bw_pkg::t_div_ctl              i_ctl,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bw_pkg::WeightW-1:0]    o_weight_a,
    output logic [bw_pkg::WeightW-1:0]    o_weight_b,
    output logic [bw_pkg::WeightW-1:0]    o_weight_c,
    output logic                          o_degen,
    output logic                          o_sat
);
    import bw_pkg::*;

    logic [2:0] r_v;
    logic [2:0] w_rdy;

    logic signed [SqW-1:0]  r_q1, r_q2;
    logic                   r_degen0, r_degen1;
    logic signed [SumW-1:0] r_q0;
    t_sat_w                 r_w1, r_w2;
    logic [WeightW-1:0]     r_wa, r_wb, r_wc;
    logic                   r_degen, r_sat;
    t_sat_w                 w_w0;
    logic signed [SumW-1:0] w_q1x, w_q2x;

    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    // Restore the quotient signs.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_q1     <= i_ctl.q1_neg ? -$signed({1'b0, i_q1_mag}) : $signed({1'b0, i_q1_mag});
            r_q2     <= i_ctl.q2_neg ? -$signed({1'b0, i_q2_mag}) : $signed({1'b0, i_q2_mag});
            r_degen0 <= i_ctl.degen;
        end
    end

    assign w_q1x = SumW'(r_q1);
    assign w_q2x = SumW'(r_q2);

    // Weight of A from the unclipped weights; clip the other two.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_q0     <= OneQ16 - w_q1x - w_q2x;
            r_w1     <= clamp_w(w_q1x);
            r_w2     <= clamp_w(w_q2x);
            r_degen1 <= r_degen0;
        end
    end

    assign w_w0 = clamp_w(r_q0);

    // Output word; a zero area forces zero weights and no saturation.
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_degen <= r_degen1;
            if (r_degen1) begin
                r_wa  <= '0;
                r_wb  <= '0;
                r_wc  <= '0;
                r_sat <= 1'b0;
            end else begin
                r_wa  <= w_w0.w;
                r_wb  <= r_w1.w;
                r_wc  <= r_w2.w;
                r_sat <= w_w0.sat | r_w1.sat | r_w2.sat;
            end
        end
    end

    assign o_valid    = r_v[2];
    assign o_weight_a = r_wa;
    assign o_weight_b = r_wb;
    assign o_weight_c = r_wc;
    assign o_degen    = r_degen;
    assign o_sat      = r_sat;

endmodule
